### design/obpl_pkg.sv
// Package for the order book price level table.
// Holds constants, beat payload types and the sequencer state encoding.
`default_nettype none
package obpl_pkg;

  localparam int LEVEL_CAPACITY = 32;
  localparam logic [4:0] DEPTH_RESET = 5'd10;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [47:0] stamp_ms;
    logic        batch_end;
  } upd_t;

  typedef struct packed {
    logic [31:0] best_bid_price;
    logic [31:0] best_bid_qty;
    logic [31:0] best_ask_price;
    logic [31:0] best_ask_qty;
    logic [5:0]  bid_count;
    logic [5:0]  ask_count;
    logic [47:0] book_time_ms;
  } book_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_FINISH,
    ST_CHECK,
    ST_TOP_BID,
    ST_TOP_ASK,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

### design/obpl_stream_if.sv
// Valid/ready channel carrying one payload per beat.
// Payload type is a parameter; used for updates, results and configuration.
`default_nettype none
interface obpl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/order_book_price_levels.sv
// Order book price level table: top level and update sequencer.
// Depends on obpl_pkg, obpl_stream_if and obpl_ram.
//
// Usage:
//   upd_i  : one level update per beat (side, price, quantity, stamp, batch end).
//   book_o : top of book and level counts, one beat per batch end whose
//            book has both sides non-empty after the depth cut.
//   cfg_i  : depth_limit write, always taken; write only while idle.
// Both sides live in one RAM, bids in the lower half and asks in the upper,
// each kept sorted best level first. An update scans its side one entry at a
// time (ST_SCAN_RD, ST_SCAN_CHK) until it finds the price or its sorted place,
// then shifts the tail one entry at a time (ST_SHIFT_RD, ST_SHIFT_WR) through
// the single RAM port pair; the scan and the shift together cover at most one
// side. One update is in work at a time.
// Reset empties both sides, clears the book time and sets depth_limit to 10;
// the RAM is not cleared, entries at or above the held count are never read.
// The result sits in an output register; a stalled receiver holds the block
// only when a new result is ready and the register is still full.
`default_nettype none
module order_book_price_levels #(
  parameter int LEVEL_CAPACITY = obpl_pkg::LEVEL_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  obpl_stream_if.sink   upd_i,
  obpl_stream_if.source book_o,
  obpl_stream_if.sink   cfg_i
);
  localparam int CNT_W = $clog2(LEVEL_CAPACITY + 1);
  localparam int IDX_W = $clog2(LEVEL_CAPACITY);
  localparam int AW    = IDX_W + 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(LEVEL_CAPACITY);

  obpl_pkg::state_e state_q, state_d;
  obpl_pkg::upd_t   upd_q;
  obpl_pkg::book_t  book_q, book_d;
  logic             book_vld_q, book_vld_d;
  logic [4:0]       depth_q;
  logic [CNT_W-1:0] bid_held_q, bid_held_d, ask_held_q, ask_held_d;
  logic [CNT_W-1:0] pos_q, pos_d, cur_q, cur_d, lim_q, lim_d;
  logic             match_q, match_d, del_q, del_d;
  logic [47:0]      time_q, time_d;
  logic [63:0]      bid_top_q, bid_top_d;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [63:0]      wdata, rdata;
  logic [CNT_W-1:0] n_side;
  logic [31:0]      ent_price;
  logic             ahead;
  logic [CNT_W-1:0] cur_inc, cur_dec;

  obpl_ram #(.WIDTH(64), .DEPTH(2 ** AW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign upd_i.ready  = (state_q == obpl_pkg::ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign book_o.valid = book_vld_q;
  assign book_o.data  = book_q;

  assign n_side    = upd_q.side ? ask_held_q : bid_held_q;
  assign ent_price = rdata[63:32];
  assign ahead     = upd_q.side ? (upd_q.price < ent_price) : (upd_q.price > ent_price);
  assign cur_inc   = CNT_W'(cur_q + 1'b1);
  assign cur_dec   = CNT_W'(cur_q - 1'b1);

  // sequence one update through scan, shift, cut and report
  always_comb begin
    logic [CMP_W-1:0] dl;
    dl         = CMP_W'(depth_q);
    state_d    = state_q;
    bid_held_d = bid_held_q;
    ask_held_d = ask_held_q;
    pos_d      = pos_q;
    cur_d      = cur_q;
    lim_d      = lim_q;
    match_d    = match_q;
    del_d      = del_q;
    time_d     = time_q;
    bid_top_d  = bid_top_q;
    book_d     = book_q;
    book_vld_d = book_vld_q && !book_o.ready;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = {upd_q.side, cur_q[IDX_W-1:0]};
    raddr      = {upd_q.side, pos_q[IDX_W-1:0]};
    wdata      = rdata;

    unique case (state_q)
      obpl_pkg::ST_IDLE: begin
        pos_d   = '0;
        match_d = 1'b0;
        if (upd_i.valid) begin
          state_d = obpl_pkg::ST_SCAN_RD;
        end
      end
      obpl_pkg::ST_SCAN_RD: begin
        if (pos_q == n_side) begin
          state_d = obpl_pkg::ST_DECIDE;
        end else begin
          re      = 1'b1;
          state_d = obpl_pkg::ST_SCAN_CHK;
        end
      end
      obpl_pkg::ST_SCAN_CHK: begin
        if (ent_price == upd_q.price) begin
          match_d = 1'b1;
          state_d = obpl_pkg::ST_DECIDE;
        end else if (ahead) begin
          state_d = obpl_pkg::ST_DECIDE;
        end else begin
          pos_d   = CNT_W'(pos_q + 1'b1);
          state_d = obpl_pkg::ST_SCAN_RD;
        end
      end
      obpl_pkg::ST_DECIDE: begin
        cur_d = pos_q;
        lim_d = n_side;
        if (match_q) begin
          if (upd_q.quantity != '0) begin
            state_d = obpl_pkg::ST_PUT;
          end else begin
            del_d   = 1'b1;
            state_d = obpl_pkg::ST_SHIFT_RD;
            if (upd_q.side) ask_held_d = CNT_W'(ask_held_q - 1'b1);
            else            bid_held_d = CNT_W'(bid_held_q - 1'b1);
          end
        end else if (upd_q.quantity == '0) begin
          state_d = obpl_pkg::ST_FINISH;
        end else if (n_side == CAP_C && pos_q == CAP_C) begin
          // worse than every level of a full side: drop it
          state_d = obpl_pkg::ST_FINISH;
        end else begin
          del_d   = 1'b0;
          state_d = obpl_pkg::ST_SHIFT_RD;
          cur_d   = (n_side == CAP_C) ? CNT_W'(CAP_C - 1'b1) : n_side;
          if (upd_q.side) ask_held_d = CNT_W'(cur_d + 1'b1);
          else            bid_held_d = CNT_W'(cur_d + 1'b1);
        end
      end
      obpl_pkg::ST_SHIFT_RD: begin
        if (del_q) begin
          raddr = {upd_q.side, cur_inc[IDX_W-1:0]};
          if (cur_inc < lim_q) begin
            re      = 1'b1;
            state_d = obpl_pkg::ST_SHIFT_WR;
          end else begin
            state_d = obpl_pkg::ST_FINISH;
          end
        end else begin
          raddr = {upd_q.side, cur_dec[IDX_W-1:0]};
          if (cur_q > pos_q) begin
            re      = 1'b1;
            state_d = obpl_pkg::ST_SHIFT_WR;
          end else begin
            state_d = obpl_pkg::ST_PUT;
          end
        end
      end
      obpl_pkg::ST_SHIFT_WR: begin
        we      = 1'b1;
        cur_d   = del_q ? cur_inc : cur_dec;
        state_d = obpl_pkg::ST_SHIFT_RD;
      end
      obpl_pkg::ST_PUT: begin
        we      = 1'b1;
        waddr   = {upd_q.side, pos_q[IDX_W-1:0]};
        wdata   = {upd_q.price, upd_q.quantity};
        state_d = obpl_pkg::ST_FINISH;
      end
      obpl_pkg::ST_FINISH: begin
        if (!upd_q.batch_end) begin
          state_d = obpl_pkg::ST_IDLE;
        end else begin
          // cut both sides to the depth limit
          if (CMP_W'(bid_held_q) > dl) bid_held_d = CNT_W'(dl);
          if (CMP_W'(ask_held_q) > dl) ask_held_d = CNT_W'(dl);
          time_d  = upd_q.stamp_ms;
          state_d = obpl_pkg::ST_CHECK;
        end
      end
      obpl_pkg::ST_CHECK: begin
        state_d = (bid_held_q != '0 && ask_held_q != '0) ? obpl_pkg::ST_TOP_BID
                                                         : obpl_pkg::ST_IDLE;
      end
      obpl_pkg::ST_TOP_BID: begin
        re      = 1'b1;
        raddr   = '0;
        state_d = obpl_pkg::ST_TOP_ASK;
      end
      obpl_pkg::ST_TOP_ASK: begin
        re        = 1'b1;
        raddr     = {1'b1, {IDX_W{1'b0}}};
        bid_top_d = rdata;
        state_d   = obpl_pkg::ST_EMIT;
      end
      obpl_pkg::ST_EMIT: begin
        // wait for the output register to drain
        if (!book_vld_q || book_o.ready) begin
          book_vld_d            = 1'b1;
          book_d.best_bid_price = bid_top_q[63:32];
          book_d.best_bid_qty   = bid_top_q[31:0];
          book_d.best_ask_price = rdata[63:32];
          book_d.best_ask_qty   = rdata[31:0];
          book_d.bid_count      = 6'(bid_held_q);
          book_d.ask_count      = 6'(ask_held_q);
          book_d.book_time_ms   = time_q;
          state_d               = obpl_pkg::ST_IDLE;
        end
      end
      default: state_d = obpl_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= obpl_pkg::ST_IDLE;
      book_vld_q <= 1'b0;
      bid_held_q <= '0;
      ask_held_q <= '0;
      time_q     <= '0;
      depth_q    <= obpl_pkg::DEPTH_RESET;
    end else begin
      state_q    <= state_d;
      book_vld_q <= book_vld_d;
      bid_held_q <= bid_held_d;
      ask_held_q <= ask_held_d;
      time_q     <= time_d;
      if (cfg_i.valid) begin
        depth_q <= cfg_i.data;
      end
    end
  end

  // payload and loop registers
  always_ff @(posedge clk_i) begin
    if (upd_i.valid && upd_i.ready) begin
      upd_q <= upd_i.data;
    end
    book_q    <= book_d;
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    lim_q     <= lim_d;
    match_q   <= match_d;
    del_q     <= del_d;
    bid_top_q <= bid_top_d;
  end

  a_held_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bid_held_q <= CAP_C && ask_held_q <= CAP_C)
    else $error("level count above capacity");

  a_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == obpl_pkg::ST_CHECK |-> CMP_W'(bid_held_q) <= CMP_W'(depth_q)
                                     && CMP_W'(ask_held_q) <= CMP_W'(depth_q))
    else $error("side not cut to depth at batch end");

  a_result_sides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == obpl_pkg::ST_EMIT |-> bid_held_q != '0 && ask_held_q != '0)
    else $error("result for a one-sided book");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == obpl_pkg::ST_IDLE |-> !we)
    else $error("RAM write while idle");

endmodule
`default_nettype wire

### design/obpl_ram.sv
// Generic single write, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module obpl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, hold data when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

### bench/order_book_price_levels_test.sv
// Testbench for order_book_price_levels: directed and random level updates
// with a behavioral book model; depends on obpl_pkg and obpl_stream_if.
module order_book_price_levels_test;

  localparam int CAP       = obpl_pkg::LEVEL_CAPACITY;
  localparam int DUE_DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  obpl_stream_if #(.T(obpl_pkg::upd_t))  upd_ch ();
  obpl_stream_if #(.T(obpl_pkg::book_t)) book_ch ();
  obpl_stream_if #(.T(logic [4:0]))      cfg_ch ();

  order_book_price_levels i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd_ch.sink),
    .book_o (book_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  always #4 clk_i = ~clk_i;

  // Model state of the book
  logic [31:0] bid_px [CAP];
  logic [31:0] bid_qt [CAP];
  logic [31:0] ask_px [CAP];
  logic [31:0] ask_qt [CAP];
  int          bid_held;
  int          ask_held;
  logic [4:0]  depth_lim;

  // Predicted results, oldest at due_rd
  obpl_pkg::book_t due_mem [DUE_DEPTH];
  int    due_wr = 0;
  int    due_rd = 0;
  int    mismatch_count = 0;
  bit    idle_sink = 1'b0;
  int    sink_left = 0;

  // Apply one level update to one side of the model
  task automatic apply_level(input bit is_ask, input logic [31:0] px,
                             input logic [31:0] qt);
    logic [31:0] p [CAP];
    logic [31:0] q [CAP];
    int n;
    int i;
    int j;
    bit ahead;
    n = is_ask ? ask_held : bid_held;
    for (j = 0; j < CAP; j++) begin
      p[j] = is_ask ? ask_px[j] : bid_px[j];
      q[j] = is_ask ? ask_qt[j] : bid_qt[j];
    end
    i = 0;
    while (i < n && p[i] != px) i++;
    if (i < n) begin
      if (qt == 0) begin
        for (j = i; j < n - 1; j++) begin
          p[j] = p[j + 1];
          q[j] = q[j + 1];
        end
        n--;
      end else begin
        q[i] = qt;
      end
    end else if (qt != 0) begin
      i = 0;
      while (i < n) begin
        ahead = is_ask ? (px < p[i]) : (px > p[i]);
        if (ahead) break;
        i++;
      end
      if (!(n >= CAP && i >= CAP)) begin
        if (n >= CAP) n = CAP - 1;
        for (j = n; j > i; j--) begin
          p[j] = p[j - 1];
          q[j] = q[j - 1];
        end
        p[i] = px;
        q[i] = qt;
        n++;
      end
    end
    for (j = 0; j < CAP; j++) begin
      if (is_ask) begin
        ask_px[j] = p[j];
        ask_qt[j] = q[j];
      end else begin
        bid_px[j] = p[j];
        bid_qt[j] = q[j];
      end
    end
    if (is_ask) ask_held = n; else bid_held = n;
  endtask

  // Predict the top of book caused by one update
  task automatic predict_book(input obpl_pkg::upd_t u);
    obpl_pkg::book_t b;
    apply_level(u.side, u.price, u.quantity);
    if (u.batch_end) begin
      if (bid_held > depth_lim) bid_held = depth_lim;
      if (ask_held > depth_lim) ask_held = depth_lim;
      if (bid_held != 0 && ask_held != 0) begin
        b.best_bid_price = bid_px[0];
        b.best_bid_qty   = bid_qt[0];
        b.best_ask_price = ask_px[0];
        b.best_ask_qty   = ask_qt[0];
        b.bid_count      = 6'(bid_held);
        b.ask_count      = 6'(ask_held);
        b.book_time_ms   = u.stamp_ms;
        due_mem[due_wr % DUE_DEPTH] = b;
        due_wr++;
      end
    end
  endtask

  // Send one update beat after a random gap
  task automatic send_update(input logic side, input logic [31:0] px,
                             input logic [31:0] qt, input bit last);
    obpl_pkg::upd_t u;
    int gap;
    u.side = side;
    u.price = px;
    u.quantity = qt;
    u.stamp_ms = 48'({$urandom, $urandom});
    u.batch_end = last;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk_i);
    upd_ch.valid <= 1'b1;
    upd_ch.data  <= u;
    @(posedge clk_i);
    while (!upd_ch.ready) @(posedge clk_i);
    upd_ch.valid <= 1'b0;
    predict_book(u);
    // let valid settle low before the next beat is driven
    @(posedge clk_i);
  endtask

  // Wait for the book to drain, then write depth_limit
  task automatic write_depth(input logic [4:0] d);
    while (due_wr != due_rd) @(posedge clk_i);
    repeat (4 * CAP + 20) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= d;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    depth_lim = d;
  endtask

  // Hold ready low for a drawn number of cycles before each result beat
  always @(posedge clk_i) begin
    int w;
    if (book_ch.valid && book_ch.ready) begin
      w = idle_sink ? 0 : $urandom_range(0, 9);
      sink_left     <= w;
      book_ch.ready <= (w == 0);
    end else if (!book_ch.ready) begin
      if (sink_left <= 1) book_ch.ready <= 1'b1;
      if (sink_left != 0) sink_left <= sink_left - 1;
    end
  end

  // Compare each result beat with the oldest predicted top of book
  always @(posedge clk_i) begin
    obpl_pkg::book_t want;
    if (rst_ni && book_ch.valid && book_ch.ready) begin
      if (due_wr == due_rd) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected book beat %p", book_ch.data);
      end else begin
        want = due_mem[due_rd % DUE_DEPTH];
        due_rd++;
        if (want != book_ch.data) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("book mismatch: expected %p actual %p", want, book_ch.data);
        end
      end
    end
  end

  // Extremes, deletes, absent deletes, one-sided batches, price zero
  task automatic test_directed();
    send_update(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_update(1'b1, 32'h0, 32'h1, 1'b1);
    send_update(1'b1, 32'hFFFF_FFFF, 32'h5, 1'b0);
    send_update(1'b0, 32'h0, 32'h7, 1'b0);
    send_update(1'b0, 32'h0, 32'h9, 1'b1);
    send_update(1'b1, 32'h0, 32'h0, 1'b1);
    send_update(1'b1, 32'h1234, 32'h0, 1'b1);
    send_update(1'b1, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1);
    send_update(1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_update(1'b0, 32'h0, 32'h0, 1'b1);
    send_update(1'b0, 32'h100, 32'h3, 1'b1);
  endtask

  // Fill both sides past capacity, including worse-than-all inserts
  task automatic test_overflow();
    int k;
    write_depth(5'd16);
    for (k = 0; k < CAP + 4; k++) begin
      send_update(1'b0, 32'(1000 + k), 32'(k + 1), 1'b0);
      send_update(1'b1, 32'(5000 - k), 32'(k + 1), 1'b0);
    end
    send_update(1'b0, 32'd1, 32'd2, 1'b0);
    send_update(1'b1, 32'hFFFF_FFF0, 32'd2, 1'b1);
    write_depth(5'd31);
    for (k = 0; k < CAP + 2; k++)
      send_update(k[0], 32'(2000 + k * 3), 32'(k + 9), k == CAP + 1);
  endtask

  // Random batches over a narrow price band under several depths
  task automatic test_random();
    int ph;
    int k;
    int len;
    logic [31:0] base;
    logic [4:0] depths [5] = '{5'd0, 5'd1, 5'd16, 5'd5, 5'd31};
    for (ph = 0; ph < 5; ph++) begin
      write_depth(depths[ph]);
      idle_sink = (ph == 2);
      base = (ph == 3) ? 32'hFFFF_FFC0 : $urandom_range(0, 1000);
      k = 0;
      while (k < 180) begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0)
            send_update(1'($urandom), $urandom, $urandom, $urandom_range(0, 3) == 0);
          else
            send_update(1'($urandom), base + $urandom_range(0, 60),
                        ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom, len == 1);
          k++;
          len--;
        end
      end
    end
    idle_sink = 1'b0;
  endtask

  initial begin
    upd_ch.valid = 1'b0;
    upd_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    book_ch.ready = 1'b0;
    bid_held = 0;
    ask_held = 0;
    depth_lim = obpl_pkg::DEPTH_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random();
    while (due_wr != due_rd) @(posedge clk_i);
    repeat (4 * CAP + 20) @(posedge clk_i);
    if (mismatch_count == 0 && due_wr == due_rd) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
